// ===== sv/cst_pkg.sv =====
// cst_pkg: shared types and constants for the character stream tokenizer
// depends on nothing; used by cst_core, cst_fifo and char_stream_tokenizer
package cst_pkg;

    localparam int unsigned MAX_TEXT = 65536;
    localparam int unsigned POS_W    = 16;
    localparam int unsigned CAP_INT  = (MAX_TEXT - 1 > 65535) ? 65535 : MAX_TEXT - 1;
    localparam logic [POS_W-1:0] POS_CAP = POS_W'(CAP_INT);

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;

    // result queue depth, room for two beats is needed before a byte fires
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        QM_NONE   = 2'd0,
        QM_DOUBLE = 2'd1,
        QM_SINGLE = 2'd2
    } quote_mode_t;

    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_SPACE = 2'd1,
        CLS_PUNCT = 2'd2
    } byte_class_t;

    typedef struct packed {
        logic [POS_W-1:0] token_start;
        logic [POS_W-1:0] token_length;
        logic             last_of_run;
        logic             bad_string;
    } result_t;

    // handoff from the core to the result queue
    typedef struct packed {
        logic    push0;
        logic    push1;
        result_t res0;
        result_t res1;
    } push_t;

endpackage

// ===== sv/cst_core.sv =====
// cst_core: input register plus tokenizer state and classification logic
// depends on cst_pkg
module cst_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    input  logic               room,
    output cst_pkg::push_t     push
);

    logic                        valid_reg;
    logic [7:0]                  byte_reg;
    logic [cst_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [cst_pkg::POS_W-1:0]   pend_reg, pend_next;
    cst_pkg::quote_mode_t        qm_reg, qm_next;
    logic                        bs_reg, bs_next;
    logic                        halted_reg, halted_next;

    logic                        fire;
    logic [cst_pkg::POS_W-1:0]   len;
    logic [cst_pkg::POS_W-1:0]   pos_sat;
    cst_pkg::quote_mode_t        kind;
    cst_pkg::quote_mode_t        qm_work;
    logic [cst_pkg::POS_W-1:0]   pend_work;
    logic                        is_quote;
    logic                        bad;
    cst_pkg::byte_class_t        cls;

    function automatic cst_pkg::byte_class_t classify(input logic [7:0] c);
        cst_pkg::byte_class_t r;
        case (c)
            8'h20, 8'h09, 8'h0A, 8'h0D: r = cst_pkg::CLS_SPACE;
            8'h2D, 8'h2B, 8'h2A, 8'h2F, 8'h5B, 8'h5D, 8'h7B, 8'h7D,
            8'h3B, 8'h3D, 8'h21, 8'h40, 8'h2C, 8'h24, 8'h7E, 8'h60,
            8'h25, 8'h5E, 8'h26, 8'h28, 8'h29, 8'h23, 8'h2E, 8'h3F:
                r = cst_pkg::CLS_PUNCT;
            default: r = cst_pkg::CLS_OTHER;
        endcase
        return r;
    endfunction

    assign fire     = valid_reg && room;
    assign in_ready = !valid_reg || room;

    assign len     = (pos_reg >= pend_reg) ? (pos_reg - pend_reg) : '0;
    assign pos_sat = (pos_reg >= cst_pkg::POS_CAP) ? cst_pkg::POS_CAP
                                                   : pos_reg + 1'b1;
    assign is_quote = (byte_reg == cst_pkg::CH_DQUOTE) || (byte_reg == cst_pkg::CH_SQUOTE);
    assign kind     = (byte_reg == cst_pkg::CH_DQUOTE) ? cst_pkg::QM_DOUBLE
                                                       : cst_pkg::QM_SINGLE;
    assign cls      = classify(byte_reg);

    always_comb
    begin
        pos_next    = pos_reg;
        pend_next   = pend_reg;
        qm_next     = qm_reg;
        bs_next     = bs_reg;
        halted_next = halted_reg;
        qm_work     = qm_reg;
        pend_work   = pend_reg;
        bad         = 1'b0;
        push        = '0;
        push.res0.token_start  = pend_reg;
        push.res0.token_length = len;
        push.res1.token_start  = pos_reg;
        push.res1.token_length = cst_pkg::POS_W'(1);
        push.res1.last_of_run  = 1'b1;

        if (fire)
        begin
            if (byte_reg == cst_pkg::CH_NUL)
            begin
                pos_next    = '0;
                pend_next   = '0;
                qm_next     = cst_pkg::QM_NONE;
                bs_next     = 1'b0;
                halted_next = 1'b0;
            end
            else if (!halted_reg)
            begin
                if (is_quote)
                begin
                    if (qm_reg != cst_pkg::QM_NONE && qm_reg == kind)
                    begin
                        if (bs_reg)
                            bad = 1'b1;
                        else
                            qm_work = cst_pkg::QM_NONE;
                    end
                    else if (qm_reg == cst_pkg::QM_NONE)
                    begin
                        pend_work = pos_reg;
                        qm_work   = kind;
                    end
                end

                if (bad)
                begin
                    // report the bad closing quote and freeze until a nul
                    push.push0            = 1'b1;
                    push.res0.last_of_run = 1'b1;
                    push.res0.bad_string  = 1'b1;
                    halted_next           = 1'b1;
                end
                else
                begin
                    if (qm_work == cst_pkg::QM_NONE)
                    begin
                        case (cls)
                            cst_pkg::CLS_SPACE:
                            begin
                                push.push0            = 1'b1;
                                push.res0.last_of_run = 1'b1;
                                pend_work             = pos_sat;
                            end
                            cst_pkg::CLS_PUNCT:
                            begin
                                push.push0 = 1'b1;
                                push.push1 = 1'b1;
                                pend_work  = pos_sat;
                            end
                            default: ;
                        endcase
                    end
                    qm_next   = qm_work;
                    pend_next = pend_work;
                    bs_next   = (byte_reg == cst_pkg::CH_BACKSLASH) ? ~bs_reg : 1'b0;
                    pos_next  = pos_sat;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            pos_reg    <= '0;
            pend_reg   <= '0;
            qm_reg     <= cst_pkg::QM_NONE;
            bs_reg     <= 1'b0;
            halted_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                valid_reg <= in_valid;
            pos_reg    <= pos_next;
            pend_reg   <= pend_next;
            qm_reg     <= qm_next;
            bs_reg     <= bs_next;
            halted_reg <= halted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= in_byte;
    end

    a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.push1 |-> push.push0)
        else $error("second beat pushed without the first");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (halted_reg && byte_reg != cst_pkg::CH_NUL) |-> !push.push0)
        else $error("result produced while halted");

    a_bad_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (push.push0 && push.res0.bad_string) |=> halted_reg)
        else $error("bad string did not halt the tokenizer");

    a_no_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |-> (!push.push0 ##1 $stable(pos_reg)))
        else $error("state moved without a byte");

endmodule

// ===== sv/cst_fifo.sv =====
// cst_fifo: small result queue taking up to two beats per cycle, one out
// depends on cst_pkg
module cst_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  cst_pkg::push_t   push,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output cst_pkg::result_t out_data
);

    localparam logic [cst_pkg::FIFO_AW:0] DEPTH_C = (cst_pkg::FIFO_AW + 1)'(cst_pkg::FIFO_DEPTH);

    cst_pkg::result_t            mem [cst_pkg::FIFO_DEPTH];
    logic [cst_pkg::FIFO_AW-1:0] wr_reg, rd_reg;
    logic [cst_pkg::FIFO_AW:0]   count_reg;
    logic                        pop;
    logic [cst_pkg::FIFO_AW:0]   n_push;
    logic [cst_pkg::FIFO_AW-1:0] wr_plus1;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_reg];
    assign room      = (count_reg <= DEPTH_C - 2'd2);
    assign n_push    = (cst_pkg::FIFO_AW + 1)'(push.push0) + (cst_pkg::FIFO_AW + 1)'(push.push1);
    assign wr_plus1  = wr_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_reg + n_push[cst_pkg::FIFO_AW-1:0];
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            count_reg <= count_reg + n_push - (cst_pkg::FIFO_AW + 1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
            mem[wr_reg] <= push.res0;
        if (push.push1)
            mem[wr_plus1] <= push.res1;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.push0 |-> room)
        else $error("push without room for two beats");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 count_reg == $past(count_reg) + $past(n_push)
                         - (cst_pkg::FIFO_AW + 1)'($past(pop)))
        else $error("queue count out of step with pushes and pops");

endmodule

// ===== sv/char_stream_tokenizer.sv =====
// char_stream_tokenizer: splits a byte stream into tokens at whitespace and punctuation
// path: an accepted byte is registered; its beats then enter the queue behind queued beats
// throughput: one byte per cycle; a punctuation byte gives two beats that drain one per cycle
// rate is set by the single output port of the result queue; input stalls below two free slots
// reset: rst_n asynchronously clears position, token start, quote mode, halt flag and queue
// depends on cst_pkg, cst_core, cst_fifo
module char_stream_tokenizer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] token_start,
    output logic [15:0] token_length,
    output logic        last_of_run,
    output logic        bad_string
);

    cst_pkg::push_t   push;
    cst_pkg::result_t head;
    logic             room;

    cst_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (text_byte),
        .room     (room),
        .push     (push)
    );

    cst_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (head)
    );

    assign token_start  = head.token_start;
    assign token_length = head.token_length;
    assign last_of_run  = head.last_of_run;
    assign bad_string   = head.bad_string;

endmodule

// ===== tb/sv/tb.sv =====
// tb: self-checking bench for char_stream_tokenizer, driven from plain tasks
// a token tracker predicts the beats of every accepted byte and checks output beats in order
// depends on cst_pkg and the char_stream_tokenizer rtl
module tb;

    localparam int STALL_LIMIT = 2000;
    localparam int MAX_SHOWN   = 10;
    localparam int RANDOM_END  = 1200;

    class token_tracker;
        cst_pkg::result_t          expected_tokens[$];
        logic [cst_pkg::POS_W-1:0] byte_pos;
        logic [cst_pkg::POS_W-1:0] tok_start;
        cst_pkg::quote_mode_t      qmode;
        bit                        bs_odd;
        bit                        halted;
        int                        checked;
        int                        mismatches;
        int                        bad_reports;

        function new();
            clear_state();
            checked     = 0;
            mismatches  = 0;
            bad_reports = 0;
        endfunction

        function void clear_state();
            byte_pos  = '0;
            tok_start = '0;
            qmode     = cst_pkg::QM_NONE;
            bs_odd    = 1'b0;
            halted    = 1'b0;
        endfunction

        function logic [cst_pkg::POS_W-1:0] step_pos(logic [cst_pkg::POS_W-1:0] p);
            return (p >= cst_pkg::POS_CAP) ? cst_pkg::POS_CAP : p + 1'b1;
        endfunction

        function void push_token(logic [cst_pkg::POS_W-1:0] start,
                                 logic [cst_pkg::POS_W-1:0] len,
                                 logic last, logic bad);
            cst_pkg::result_t r;
            r.token_start  = start;
            r.token_length = len;
            r.last_of_run  = last;
            r.bad_string   = bad;
            expected_tokens.push_back(r);
        endfunction

        function void note_byte(logic [7:0] c);
            logic [cst_pkg::POS_W-1:0] pos;
            logic [cst_pkg::POS_W-1:0] len;
            cst_pkg::quote_mode_t      kind;
            cst_pkg::byte_class_t      cls;
            pos = byte_pos;
            len = (pos >= tok_start) ? pos - tok_start : '0;
            if (c == cst_pkg::CH_NUL)
            begin
                clear_state();
                return;
            end
            if (halted)
                return;
            if (c == cst_pkg::CH_DQUOTE || c == cst_pkg::CH_SQUOTE)
            begin
                kind = (c == cst_pkg::CH_DQUOTE) ? cst_pkg::QM_DOUBLE : cst_pkg::QM_SINGLE;
                if (qmode != cst_pkg::QM_NONE && qmode == kind)
                begin
                    // closing quote right after an odd backslash run
                    if (bs_odd)
                    begin
                        push_token(tok_start, len, 1'b1, 1'b1);
                        halted = 1'b1;
                        return;
                    end
                    qmode = cst_pkg::QM_NONE;
                end
                else if (qmode == cst_pkg::QM_NONE)
                begin
                    tok_start = pos;
                    qmode     = kind;
                end
            end
            if (qmode == cst_pkg::QM_NONE)
            begin
                case (c)
                    8'h20, 8'h09, 8'h0A, 8'h0D:
                        cls = cst_pkg::CLS_SPACE;
                    8'h2D, 8'h2B, 8'h2A, 8'h2F, 8'h5B, 8'h5D, 8'h7B, 8'h7D,
                    8'h3B, 8'h3D, 8'h21, 8'h40, 8'h2C, 8'h24, 8'h7E, 8'h60,
                    8'h25, 8'h5E, 8'h26, 8'h28, 8'h29, 8'h23, 8'h2E, 8'h3F:
                        cls = cst_pkg::CLS_PUNCT;
                    default:
                        cls = cst_pkg::CLS_OTHER;
                endcase
                if (cls == cst_pkg::CLS_SPACE)
                begin
                    push_token(tok_start, len, 1'b1, 1'b0);
                    tok_start = step_pos(pos);
                end
                else if (cls == cst_pkg::CLS_PUNCT)
                begin
                    push_token(tok_start, len, 1'b0, 1'b0);
                    push_token(pos, 16'd1, 1'b1, 1'b0);
                    tok_start = step_pos(pos);
                end
            end
            bs_odd   = (c == cst_pkg::CH_BACKSLASH) ? !bs_odd : 1'b0;
            byte_pos = step_pos(pos);
        endfunction

        function void check_token(cst_pkg::result_t got);
            cst_pkg::result_t want;
            if (got.bad_string === 1'b1)
                bad_reports++;
            if (expected_tokens.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected token beat: start=%0d len=%0d last=%b bad=%b",
                             got.token_start, got.token_length, got.last_of_run,
                             got.bad_string);
                return;
            end
            want = expected_tokens.pop_front();
            checked++;
            if (got.token_start !== want.token_start || got.token_length !== want.token_length
                || got.last_of_run !== want.last_of_run || got.bad_string !== want.bad_string)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display({"token mismatch: expected start=%0d len=%0d last=%b bad=%b,",
                              " got start=%0d len=%0d last=%b bad=%b"},
                             want.token_start, want.token_length, want.last_of_run,
                             want.bad_string, got.token_start, got.token_length,
                             got.last_of_run, got.bad_string);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  text_byte;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;
    logic        bad_string;

    token_tracker tracker;
    bit           tx_idle_on;
    bit           rx_idle_on;
    int           sent_count;
    int           idle_cycles = 0;
    int           leftover;

    char_stream_tokenizer uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .text_byte    (text_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_start  (token_start),
        .token_length (token_length),
        .last_of_run  (last_of_run),
        .bad_string   (bad_string)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [7:0] pick_plain();
        case ($urandom_range(0, 3))
            0:       return 8'h61 + 8'($urandom_range(0, 25));
            1:       return 8'h41 + 8'($urandom_range(0, 25));
            2:       return 8'h30 + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 3))
            0:       return 8'h20;
            1:       return 8'h09;
            2:       return 8'h0A;
            default: return 8'h0D;
        endcase
    endfunction

    function automatic logic [7:0] pick_punct();
        case ($urandom_range(0, 23))
            0:  return 8'h2D;
            1:  return 8'h2B;
            2:  return 8'h2A;
            3:  return 8'h2F;
            4:  return 8'h5B;
            5:  return 8'h5D;
            6:  return 8'h7B;
            7:  return 8'h7D;
            8:  return 8'h3B;
            9:  return 8'h3D;
            10: return 8'h21;
            11: return 8'h40;
            12: return 8'h2C;
            13: return 8'h24;
            14: return 8'h7E;
            15: return 8'h60;
            16: return 8'h25;
            17: return 8'h5E;
            18: return 8'h26;
            19: return 8'h28;
            20: return 8'h29;
            21: return 8'h23;
            22: return 8'h2E;
            default: return 8'h3F;
        endcase
    endfunction

    function automatic logic [7:0] pick_separator();
        return $urandom_range(0, 1) ? pick_space() : pick_punct();
    endfunction

    // one beat on the byte channel; valid stays up back to back when the gap is zero
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 16) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        text_byte = b;
        do @(posedge clk); while (in_ready !== 1'b1);
        sent_count++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        stop_sending();
        while (tracker.expected_tokens.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // quoted string with random content; a bad one ends on an odd backslash run
    task automatic send_string(input bit bad);
        logic [7:0] q;
        logic [7:0] other_q;
        bit         odd;
        int         n;
        q       = $urandom_range(0, 1) ? cst_pkg::CH_DQUOTE : cst_pkg::CH_SQUOTE;
        other_q = (q == cst_pkg::CH_DQUOTE) ? cst_pkg::CH_SQUOTE : cst_pkg::CH_DQUOTE;
        odd     = 1'b0;
        n       = $urandom_range(0, 6);
        send_byte(q);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    send_byte(pick_plain());
                    odd = 1'b0;
                end
                1:
                begin
                    send_byte(other_q);
                    odd = 1'b0;
                end
                2:
                begin
                    send_byte(pick_separator());
                    odd = 1'b0;
                end
                3:
                begin
                    send_byte(cst_pkg::CH_BACKSLASH);
                    odd = !odd;
                end
                4:
                begin
                    send_byte(cst_pkg::CH_BACKSLASH);
                    send_byte(cst_pkg::CH_BACKSLASH);
                end
                default:
                begin
                    send_byte(cst_pkg::CH_BACKSLASH);
                    send_byte(pick_plain());
                    odd = 1'b0;
                end
            endcase
        end
        if (odd != bad)
            send_byte(cst_pkg::CH_BACKSLASH);
        send_byte(q);
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && in_valid === 1'b1 && in_ready === 1'b1)
            tracker.note_byte(text_byte);
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
            tracker.check_token({token_start, token_length, last_of_run, bad_string});
    end

    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_ready === 1'b1) ||
            (out_valid === 1'b1 && out_ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("stalled for %0d cycles with %0d beats outstanding",
                     idle_cycles, tracker.expected_tokens.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // token beat receiver, stalls at random
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = rx_idle_on ? $urandom_range(0, 16) : 0;
            @(negedge clk);
            if (gap > 0)
            begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    initial
    begin
        bit paused;
        int k;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        text_byte   = 8'h00;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        sent_count  = 0;
        paused      = 1'b0;
        tracker     = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: backslash at position zero, nested quote kinds, empty tokens,
        // extreme bytes, a bad closing quote, bytes while halted, then recovery
        send_byte(cst_pkg::CH_NUL);       send_byte(cst_pkg::CH_BACKSLASH);
        send_byte(cst_pkg::CH_DQUOTE);    send_byte(8'h61);
        send_byte(cst_pkg::CH_SQUOTE);    send_byte(cst_pkg::CH_BACKSLASH);
        send_byte(cst_pkg::CH_BACKSLASH); send_byte(cst_pkg::CH_DQUOTE);
        send_byte(8'h20);                 send_byte(8'h20);
        send_byte(8'h3B);                 send_byte(8'hFF);
        send_byte(8'h80);                 send_byte(8'h09);
        send_byte(cst_pkg::CH_SQUOTE);    send_byte(8'h62);
        send_byte(cst_pkg::CH_BACKSLASH); send_byte(cst_pkg::CH_SQUOTE);
        send_byte(8'h2E);                 send_byte(8'h20);
        send_byte(cst_pkg::CH_NUL);       send_byte(8'h0A);
        send_byte(8'h0D);                 send_byte(8'h28);
        send_byte(8'h7F);                 send_byte(8'h01);
        send_byte(8'h3F);
        wait_drained();

        k = 0;
        while (sent_count < RANDOM_END)
        begin
            if (k % 40 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       begin tx_idle_on = 1'b1; rx_idle_on = 1'b1; end
                    1:       begin tx_idle_on = 1'b1; rx_idle_on = 1'b0; end
                    2:       begin tx_idle_on = 1'b0; rx_idle_on = 1'b1; end
                    default: begin tx_idle_on = 1'b0; rx_idle_on = 1'b0; end
                endcase
            end
            k++;
            if (!paused && sent_count > RANDOM_END / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
            case ($urandom_range(0, 99)) inside
                [0:39]:
                begin
                    repeat ($urandom_range(1, 8)) send_byte(pick_plain());
                    if ($urandom_range(0, 9) < 7)
                        send_byte(pick_separator());
                end
                [40:54]:
                    send_byte(pick_separator());
                [55:69]:
                begin
                    send_string(1'b0);
                    if ($urandom_range(0, 1))
                        send_byte(pick_separator());
                end
                [70:77]:
                begin
                    send_string(1'b1);
                    repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(1, 255)));
                    send_byte(cst_pkg::CH_NUL);
                end
                [78:84]:
                    send_byte(cst_pkg::CH_NUL);
                [85:92]:
                begin
                    repeat ($urandom_range(1, 4)) send_byte(cst_pkg::CH_BACKSLASH);
                    send_byte($urandom_range(0, 1) ? pick_separator() : cst_pkg::CH_DQUOTE);
                end
                default:
                    send_byte(8'($urandom_range(0, 255)));
            endcase
        end

        // closing run with no idling, bytes back to back
        wait_drained();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_byte(cst_pkg::CH_NUL);
        send_byte(8'h20);                 send_byte(8'h2E);
        send_byte(8'h20);                 send_byte(cst_pkg::CH_DQUOTE);
        send_byte(8'h62);                 send_byte(cst_pkg::CH_DQUOTE);
        send_byte(8'h2C);                 send_byte(cst_pkg::CH_SQUOTE);
        send_byte(cst_pkg::CH_BACKSLASH); send_byte(cst_pkg::CH_SQUOTE);
        send_byte(cst_pkg::CH_NUL);       send_byte(8'h20);

        wait_drained();
        repeat (8) @(posedge clk);
        leftover = tracker.expected_tokens.size();
        if (leftover != 0)
            $display("%0d expected token beats never arrived", leftover);
        $display("drove %0d text bytes, compared %0d token beats, saw %0d bad-string reports",
                 sent_count, tracker.checked, tracker.bad_reports);
        $display("covered all byte classes, both quote kinds, halting and random stalls");
        if (tracker.mismatches == 0 && leftover == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/cst_pkg.sv
sv/cst_core.sv
sv/cst_fifo.sv
sv/char_stream_tokenizer.sv
tb/sv/tb.sv
